// ===== sv/slps_pkg.sv =====
`timescale 1ns / 1ps

package slps_pkg;

    // sizes of the skeleton store and the blend
    localparam int MAX_BONES   = 64;
    localparam int INFLUENCES  = 4;
    localparam int BONE_WORDS  = 12;
    localparam int ROWS        = 3;
    localparam int COLS        = 4;
    localparam int CORNERS     = 8;
    localparam int STORE_DEPTH = MAX_BONES * BONE_WORDS;

    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int BONE_W   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int JOINT_W  = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLS);
    localparam int CORNER_W = $clog2(CORNERS);
    localparam int CFG_IDX_W = 3;

    // arithmetic widths
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 52;
    localparam int FRAC_BITS = 16;
    localparam int WGT_FRAC  = 15;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE_Q16   = 32'sh0001_0000;
    localparam logic signed [31:0] TY_Y_RESET = 32'sh0001_0000;

    typedef enum logic [1:0] {
        CMD_LOAD          = 2'd0,
        CMD_SAMPLE        = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_FINISH_BOUNDS = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HAS_SKELETON = 3'd0,
        CFG_BONE_COUNT   = 3'd1,
        CFG_TY_X         = 3'd2,
        CFG_TY_Y         = 3'd3,
        CFG_TY_Z         = 3'd4,
        CFG_TY_W         = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JOINT,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_WMUL,
        ST_WACC,
        ST_POSE,
        ST_MIN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_SKIN,
        MODE_XFORM,
        MODE_BOX
    } mode_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] bound_max_x;
        logic signed [31:0] bound_max_y;
        logic signed [31:0] bound_max_z;
        logic [31:0]        joint_indices;
        logic [63:0]        joint_weights;
        logic [5:0]         bone_index;
        logic [3:0]         matrix_element;
        logic signed [31:0] matrix_value;
    } slps_in_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] min_y;
    } slps_out_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic row_add;
        logic row_last;
    } mac_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(INT32_MAX)) begin
            r = INT32_MAX;
        end else if (v < ACC_W'(INT32_MIN)) begin
            r = INT32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/slps_mac.sv =====
`timescale 1ns / 1ps

module slps_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  slps_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [slps_pkg::MUL_W-1:0]   mul_a,
    input  logic signed [slps_pkg::MUL_W-1:0]   mul_b,
    output logic signed [slps_pkg::PROD_W-1:0]  prod,
    output logic signed [31:0]                  row_value
);
    import slps_pkg::*;

    logic signed [2*MUL_W-1:0]  full_prod;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    rsum_reg;
    logic signed [ACC_W-1:0]    rsum_next;
    logic signed [ACC_W-1:0]    term;
    logic signed [31:0]         row_value_reg;

    // shared signed multiplier, registered
    assign full_prod = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= full_prod[PROD_W-1:0];
        end
    end

    // floor shift of the product and running row sum
    assign term      = ACC_W'(prod_reg >>> FRAC_BITS);
    assign rsum_next = rsum_reg + term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsum_reg <= '0;
        end else if (ctrl.row_add) begin
            rsum_reg <= ctrl.row_last ? '0 : rsum_next;
        end
    end

    // saturated row result at the last term
    always_ff @(posedge aclk) begin
        if (ctrl.row_add && ctrl.row_last) begin
            row_value_reg <= sat32(rsum_next);
        end
    end

    assign prod      = prod_reg;
    assign row_value = row_value_reg;

endmodule

// ===== sv/skinned_lowest_point_scan.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      slps_in_t  (command, sample, box, matrix word)
// m_        out        m_valid / m_ready      slps_out_t (found, min_y)
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one shared 33x33 multiplier does every product; each matrix term goes through a store
// read, a multiply and an add. a load writes the store from idle; a sample works per
// active joint; a finish with bounds may walk the eight box corners.
// reset clears control, the running minimum and the config registers; the skin store
// is not cleared. s_ready is high only when the sequencer is idle; a result waits in
// the output register; the sequencer holds in emit while it is full and m_ready is low.

module skinned_lowest_point_scan (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  slps_pkg::slps_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output slps_pkg::slps_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import slps_pkg::*;

    // config registers
    logic               skel_reg;
    logic [6:0]         bone_count_reg;
    logic signed [31:0] ty_reg [COLS];

    // sequencer and datapath registers
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    slps_in_t           in_reg;
    logic [JOINT_W-1:0] j_reg, j_next;
    logic [ROW_W-1:0]   r_reg, r_next;
    logic [COL_W-1:0]   c_reg, c_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic signed [31:0] op_reg [ROWS];
    logic signed [31:0] op_next [ROWS];
    logic signed [ACC_W-1:0] acc_reg [ROWS];
    logic signed [ACC_W-1:0] acc_next [ROWS];
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] best_reg, best_next;
    logic               seen_reg, seen_next;
    logic               res_found_reg, res_found_next;
    logic signed [31:0] res_min_reg, res_min_next;
    logic               m_valid_reg, m_valid_next;
    slps_out_t          m_data_reg, m_data_next;

    // skin store
    logic signed [31:0] skin_mem [STORE_DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               mem_we;

    // shared unit
    mac_ctrl_t                 mac_ctrl;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [31:0]        row_value;

    // status
    logic               accept;
    logic               out_free;
    logic               fast_hit;
    logic [7:0]         joint_idx;
    logic [15:0]        joint_w;
    logic               joint_active;
    logic               joint_last, row_last, col_last, corner_last;
    logic signed [31:0] opnd [COLS];
    logic signed [31:0] best_cand;
    logic [CORNER_W-1:0] corner_inc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign fast_hit  = skel_reg && seen_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // current joint and loop ends
    assign joint_idx    = in_reg.joint_indices[8*j_reg +: 8];
    assign joint_w      = in_reg.joint_weights[16*j_reg +: 16];
    assign joint_active = (joint_w != 16'd0)
                       && (joint_idx < {1'b0, bone_count_reg})
                       && ({1'b0, joint_idx} < 9'(MAX_BONES));
    assign joint_last   = (j_reg == JOINT_W'(INFLUENCES - 1));
    assign row_last     = (r_reg == ROW_W'(ROWS - 1));
    assign col_last     = (c_reg == COL_W'(COLS - 1));
    assign corner_last  = (corner_reg == CORNER_W'(CORNERS - 1));
    assign corner_inc   = corner_reg + 1'b1;
    assign best_cand    = (row_value < best_reg) ? row_value : best_reg;

    // point operand, with the constant one for the translation column
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            opnd[i] = op_reg[i];
        end
        opnd[COLS-1] = ONE_Q16;
    end

    // store addresses
    assign rd_addr = ADDR_W'(int'(joint_idx[BONE_W-1:0]) * BONE_WORDS
                           + int'(r_reg) * COLS + int'(c_reg));
    assign wr_addr = ADDR_W'(int'(s_data.bone_index) * BONE_WORDS
                           + int'(s_data.matrix_element));

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skel_reg       <= 1'b0;
            bone_count_reg <= '0;
            ty_reg[0]      <= '0;
            ty_reg[1]      <= TY_Y_RESET;
            ty_reg[2]      <= '0;
            ty_reg[3]      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HAS_SKELETON: skel_reg       <= cfg_data[0];
                CFG_BONE_COUNT:   bone_count_reg <= cfg_data[6:0];
                CFG_TY_X:         ty_reg[0]      <= cfg_data;
                CFG_TY_Y:         ty_reg[1]      <= cfg_data;
                CFG_TY_Z:         ty_reg[2]      <= cfg_data;
                CFG_TY_W:         ty_reg[3]      <= cfg_data;
                default: ;
            endcase
        end
    end

    // skin store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            skin_mem[wr_addr] <= s_data.matrix_value;
        end
        rd_data_reg <= skin_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.cmd)
                        CMD_LOAD:          state_next = ST_IDLE;
                        CMD_SAMPLE:        state_next = ST_JOINT;
                        CMD_FINISH_BOUNDS: state_next = fast_hit ? ST_EMIT : ST_READ;
                        default:           state_next = ST_EMIT;
                    endcase
                end
            end
            ST_JOINT: begin
                if (joint_active) begin
                    state_next = ST_READ;
                end else if (joint_last) begin
                    state_next = ST_POSE;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC: begin
                if (!col_last) begin
                    state_next = ST_READ;
                end else if (mode_reg == MODE_SKIN) begin
                    state_next = ST_WMUL;
                end else begin
                    state_next = ST_MIN;
                end
            end
            ST_WMUL: state_next = ST_WACC;
            ST_WACC: begin
                if (!row_last) begin
                    state_next = ST_READ;
                end else begin
                    state_next = joint_last ? ST_POSE : ST_JOINT;
                end
            end
            ST_POSE: state_next = ST_READ;
            ST_MIN: begin
                if (mode_reg != MODE_BOX) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = corner_last ? ST_EMIT : ST_READ;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: store write, shared unit control and operands
    always_comb begin
        mem_we   = 1'b0;
        mac_ctrl = '0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mem_we = accept && (s_data.cmd == CMD_LOAD)
                      && (s_data.matrix_element < 4'(BONE_WORDS))
                      && ({3'b0, s_data.bone_index} < 9'(MAX_BONES));
            end
            ST_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                mul_a = (mode_reg == MODE_SKIN) ? MUL_W'(rd_data_reg) : MUL_W'(ty_reg[c_reg]);
                mul_b = MUL_W'(opnd[c_reg]);
            end
            ST_ACC: begin
                mac_ctrl.row_add  = 1'b1;
                mac_ctrl.row_last = col_last;
            end
            ST_WMUL: begin
                mac_ctrl.mul_en = 1'b1;
                mul_a = MUL_W'(row_value);
                mul_b = MUL_W'($signed({1'b0, joint_w}));
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        mode_next      = mode_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        corner_next    = corner_reg;
        min_next       = min_reg;
        best_next      = best_reg;
        seen_next      = seen_reg;
        res_found_next = res_found_reg;
        res_min_next   = res_min_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        for (int i = 0; i < ROWS; i++) begin
            op_next[i]  = op_reg[i];
            acc_next[i] = acc_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    j_next      = '0;
                    r_next      = '0;
                    c_next      = '0;
                    corner_next = '0;
                    best_next   = MIN_RESET;
                    op_next[0]  = s_data.pos_x;
                    op_next[1]  = s_data.pos_y;
                    op_next[2]  = s_data.pos_z;
                    for (int i = 0; i < ROWS; i++) begin
                        acc_next[i] = '0;
                    end
                    mode_next = (s_data.cmd == CMD_SAMPLE) ? MODE_SKIN : MODE_BOX;
                    // any finish reports and restarts the scan
                    if ((s_data.cmd == CMD_FINISH) || (s_data.cmd == CMD_FINISH_BOUNDS)) begin
                        res_found_next = fast_hit;
                        res_min_next   = fast_hit ? min_reg : '0;
                        min_next       = MIN_RESET;
                        seen_next      = 1'b0;
                    end
                end
            end
            ST_JOINT: begin
                if (joint_active) begin
                    r_next = '0;
                    c_next = '0;
                end else if (!joint_last) begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_ACC: begin
                c_next = col_last ? '0 : c_reg + 1'b1;
            end
            ST_WACC: begin
                acc_next[r_reg] = acc_reg[r_reg] + ACC_W'(prod);
                if (row_last) begin
                    r_next = '0;
                    if (!joint_last) begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_POSE: begin
                for (int i = 0; i < ROWS; i++) begin
                    op_next[i] = sat32(acc_reg[i] >>> WGT_FRAC);
                end
                mode_next = MODE_XFORM;
                c_next    = '0;
            end
            ST_MIN: begin
                if (mode_reg != MODE_BOX) begin
                    if (row_value < min_reg) begin
                        min_next = row_value;
                    end
                    seen_next = 1'b1;
                end else begin
                    best_next = best_cand;
                    if (corner_last) begin
                        res_found_next = 1'b1;
                        res_min_next   = best_cand;
                    end else begin
                        corner_next = corner_inc;
                        op_next[0]  = corner_inc[0] ? in_reg.bound_max_x : in_reg.pos_x;
                        op_next[1]  = corner_inc[1] ? in_reg.bound_max_y : in_reg.pos_y;
                        op_next[2]  = corner_inc[2] ? in_reg.bound_max_z : in_reg.pos_z;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_data_next.found = res_found_reg;
                    m_data_next.min_y = res_min_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_SKIN;
            j_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            corner_reg  <= '0;
            min_reg     <= MIN_RESET;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            j_reg       <= j_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            corner_reg  <= corner_next;
            min_reg     <= min_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        best_reg      <= best_next;
        res_found_reg <= res_found_next;
        res_min_reg   <= res_min_next;
        m_data_reg    <= m_data_next;
        for (int i = 0; i < ROWS; i++) begin
            op_reg[i]  <= op_next[i];
            acc_reg[i] <= acc_next[i];
        end
    end

    slps_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mac_ctrl),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .prod      (prod),
        .row_value (row_value)
    );

endmodule

// ===== verif/tb_skinned_lowest_point_scan.sv =====
`timescale 1ns / 1ps

module tb_skinned_lowest_point_scan;
    import slps_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    // longest gap after the last result: a sample with four active joints
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS  = 64;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    slps_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    slps_out_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // expected scan results and test bookkeeping
    slps_out_t expected_heights[$];
    slps_out_t want;
    int        err_count = 0;
    int        cycle_count = 0;
    int        ready_hold = 0;
    bit        idle_on = 1'b1;

    // shadow of the registers and the scan state
    logic signed [31:0] skin_words [0:STORE_DEPTH-1];
    logic signed [31:0] ty_coef [0:3];
    bit                 has_bones;
    int                 bone_limit;
    logic signed [31:0] scan_min;
    bit                 scan_hit;

    skinned_lowest_point_scan uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                ready_hold = int'($urandom_range(0, 9));
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_heights.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual found=%0b min_y=%0d",
                         $time, m_data.found, m_data.min_y);
            end else begin
                want = expected_heights.pop_front();
                if (want.found !== m_data.found || want.min_y !== m_data.min_y) begin
                    err_count++;
                    $display("%0t: result mismatch, expected found=%0b min_y=%0d,",
                             $time, want.found, want.min_y,
                             " actual found=%0b min_y=%0d", m_data.found, m_data.min_y);
                end
            end
        end
    end

    // saturate to signed 32 bits
    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > longint'(INT32_MAX)) return INT32_MAX;
        if (v < longint'(INT32_MIN)) return INT32_MIN;
        return v[31:0];
    endfunction

    // c0*x + c1*y + c2*z + c3 with floored products
    function automatic logic signed [31:0] apply_row(
        input logic signed [31:0] c0, c1, c2, c3, x, y, z);
        longint total;
        total = ((longint'(c0) * longint'(x)) >>> FRAC_BITS)
              + ((longint'(c1) * longint'(y)) >>> FRAC_BITS)
              + ((longint'(c2) * longint'(z)) >>> FRAC_BITS)
              + longint'(c3);
        return clamp_q16(total);
    endfunction

    function automatic logic signed [31:0] world_height(
        input logic signed [31:0] x, y, z);
        return apply_row(ty_coef[0], ty_coef[1], ty_coef[2], ty_coef[3], x, y, z);
    endfunction

    // update the shadow state for one accepted transaction
    function automatic void predict_transaction(input slps_in_t t);
        longint             acc [0:2];
        logic signed [31:0] posed [0:2];
        logic signed [31:0] height;
        logic signed [31:0] best;
        longint             wgt;
        int                 idx;
        int                 base;
        int                 j;
        int                 r;
        slps_out_t          res;
        case (t.cmd)
            CMD_LOAD: begin
                if (t.matrix_element < BONE_WORDS)
                    skin_words[int'(t.bone_index) * BONE_WORDS + int'(t.matrix_element)] =
                        t.matrix_value;
            end
            CMD_SAMPLE: begin
                for (r = 0; r < 3; r++) acc[r] = 0;
                for (j = 0; j < INFLUENCES; j++) begin
                    wgt = longint'(t.joint_weights[16*j +: 16]);
                    idx = int'(t.joint_indices[8*j +: 8]);
                    if (wgt != 0 && idx < bone_limit && idx < MAX_BONES) begin
                        for (r = 0; r < 3; r++) begin
                            base = idx * BONE_WORDS + r * COLS;
                            acc[r] += wgt * longint'(apply_row(skin_words[base],
                                skin_words[base + 1], skin_words[base + 2],
                                skin_words[base + 3], t.pos_x, t.pos_y, t.pos_z));
                        end
                    end
                end
                for (r = 0; r < 3; r++) posed[r] = clamp_q16(acc[r] >>> WGT_FRAC);
                height = world_height(posed[0], posed[1], posed[2]);
                if (height < scan_min) scan_min = height;
                scan_hit = 1'b1;
            end
            default: begin
                res.found = 1'b0;
                res.min_y = '0;
                if (has_bones && scan_hit) begin
                    res.found = 1'b1;
                    res.min_y = scan_min;
                end else if (t.cmd == CMD_FINISH_BOUNDS) begin
                    best = MIN_RESET;
                    for (j = 0; j < CORNERS; j++) begin
                        height = world_height(j[0] ? t.bound_max_x : t.pos_x,
                                              j[1] ? t.bound_max_y : t.pos_y,
                                              j[2] ? t.bound_max_z : t.pos_z);
                        if (height < best) best = height;
                    end
                    res.found = 1'b1;
                    res.min_y = best;
                end
                scan_min = MIN_RESET;
                scan_hit = 1'b0;
                expected_heights = {expected_heights, res};
            end
        endcase
    endfunction

    // Q16.16 value: mostly small, some extremes, some full range
    function automatic logic signed [31:0] rand_fix();
        case ($urandom_range(0, 9))
            0:       return INT32_MAX;
            1:       return INT32_MIN;
            2, 3:    return $urandom();
            default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sd524288;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // every field random, so that unused fields toggle too
    function automatic slps_in_t noise_item();
        slps_in_t t;
        t.cmd            = cmd_t'($urandom_range(0, 3));
        t.pos_x          = $urandom();
        t.pos_y          = $urandom();
        t.pos_z          = $urandom();
        t.bound_max_x    = $urandom();
        t.bound_max_y    = $urandom();
        t.bound_max_z    = $urandom();
        t.joint_indices  = $urandom();
        t.joint_weights  = {$urandom(), $urandom()};
        t.bone_index     = 6'($urandom_range(0, MAX_BONES - 1));
        t.matrix_element = 4'($urandom_range(0, 15));
        t.matrix_value   = $urandom();
        return t;
    endfunction

    function automatic slps_in_t rand_sample();
        slps_in_t t;
        int       j;
        t       = noise_item();
        t.cmd   = CMD_SAMPLE;
        t.pos_x = rand_fix();
        t.pos_y = rand_fix();
        t.pos_z = rand_fix();
        for (j = 0; j < INFLUENCES; j++) begin
            if (bone_limit > 0 && $urandom_range(0, 3) != 0)
                t.joint_indices[8*j +: 8] = 8'($urandom_range(0, bone_limit - 1));
            else
                t.joint_indices[8*j +: 8] = 8'($urandom_range(0, 255));
            t.joint_weights[16*j +: 16] = rand_weight();
        end
        return t;
    endfunction

    function automatic slps_in_t rand_finish();
        slps_in_t t;
        t             = noise_item();
        t.cmd         = ($urandom_range(0, 1) == 0) ? CMD_FINISH : CMD_FINISH_BOUNDS;
        t.pos_x       = rand_fix();
        t.pos_y       = rand_fix();
        t.pos_z       = rand_fix();
        t.bound_max_x = rand_fix();
        t.bound_max_y = rand_fix();
        t.bound_max_z = rand_fix();
        return t;
    endfunction

    // one input transaction, with an optional idle burst before it
    task automatic send_txn(input slps_in_t t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_transaction(t);
    endtask

    // wait for every result and for a sample still in flight
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_heights.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_HAS_SKELETON: has_bones  = value[0];
            CFG_BONE_COUNT:   bone_limit = int'(value[6:0]);
            CFG_TY_X:         ty_coef[0] = value;
            CFG_TY_Y:         ty_coef[1] = value;
            CFG_TY_Z:         ty_coef[2] = value;
            CFG_TY_W:         ty_coef[3] = value;
            default: ;
        endcase
    endtask

    // all registers, written while the block is idle
    task automatic apply_config(input bit skel, input logic [6:0] count,
                                input logic signed [31:0] tx, ty, tz, tw);
        wait_drain();
        write_reg(CFG_HAS_SKELETON, {31'd0, skel});
        write_reg(CFG_BONE_COUNT, {25'd0, count});
        write_reg(CFG_TY_X, tx);
        write_reg(CFG_TY_Y, ty);
        write_reg(CFG_TY_Z, tz);
        write_reg(CFG_TY_W, tw);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // finishes with the reset register values and an empty scan
    task automatic test_after_reset();
        slps_in_t t;
        t = noise_item();
        t.cmd = CMD_FINISH;
        send_txn(t);
        t = noise_item();
        t.cmd         = CMD_FINISH_BOUNDS;
        t.pos_x       = -32'sh0001_0000;
        t.pos_y       = -32'sh0002_0000;
        t.pos_z       = -32'sh0003_0000;
        t.bound_max_x = 32'sh0004_0000;
        t.bound_max_y = 32'sh0005_0000;
        t.bound_max_z = 32'sh0006_0000;
        send_txn(t);
    endtask

    // every word of every bone, so no sample reads an unwritten entry
    task automatic test_fill_store();
        slps_in_t t;
        int       bone;
        int       word;
        for (bone = 0; bone < MAX_BONES; bone++) begin
            for (word = 0; word < BONE_WORDS; word++) begin
                t = noise_item();
                t.cmd            = CMD_LOAD;
                t.bone_index     = 6'(bone);
                t.matrix_element = 4'(word);
                t.matrix_value   = rand_fix();
                send_txn(t);
            end
        end
    endtask

    // elements past row 2 must not touch the store
    task automatic test_ignored_loads();
        slps_in_t t;
        t = noise_item();
        t.cmd = CMD_LOAD;
        t.bone_index = 6'd2;
        t.matrix_element = 4'd12;
        t.matrix_value = INT32_MAX;
        send_txn(t);
        t.matrix_element = 4'd15;
        t.matrix_value = INT32_MIN;
        send_txn(t);
        t.bone_index = 6'd63;
        t.matrix_element = 4'd11;
        t.matrix_value = 32'sh0001_8000;
        send_txn(t);
        t = noise_item();
        t.cmd = CMD_SAMPLE;
        t.pos_x = 32'sh0001_0000;
        t.pos_y = -32'sh0000_8000;
        t.pos_z = 32'sh0002_0000;
        t.joint_indices = {8'd63, 8'd4, 8'd3, 8'd2};
        t.joint_weights = {16'h2000, 16'h2000, 16'h2000, 16'h2000};
        send_txn(t);
        t.cmd = CMD_FINISH;
        send_txn(t);
    endtask

    // largest and smallest positions with full weights on the end bones
    task automatic test_field_extremes();
        slps_in_t t;
        t = noise_item();
        t.cmd = CMD_SAMPLE;
        t.pos_x = INT32_MAX;
        t.pos_y = INT32_MAX;
        t.pos_z = INT32_MAX;
        t.joint_indices = {8'd2, 8'd1, 8'd0, 8'd63};
        t.joint_weights = '1;
        send_txn(t);
        t.pos_x = INT32_MIN;
        t.pos_y = INT32_MIN;
        t.pos_z = INT32_MIN;
        send_txn(t);
        // box is ignored once a skinned sample was seen
        t.cmd = CMD_FINISH_BOUNDS;
        send_txn(t);
    endtask

    // zero weights and out-of-range joints leave the origin, which still counts
    task automatic test_skipped_joints();
        slps_in_t t;
        t = noise_item();
        t.cmd = CMD_SAMPLE;
        t.joint_weights = '0;
        send_txn(t);
        t.cmd = CMD_FINISH;
        send_txn(t);
        t = noise_item();
        t.cmd = CMD_SAMPLE;
        t.joint_indices = {8'd127, 8'd255, 8'd200, 8'd64};
        t.joint_weights = {16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF};
        send_txn(t);
        t.cmd = CMD_FINISH;
        send_txn(t);
    endtask

    // no samples since the last finish: not found, or the box
    task automatic test_empty_scan();
        slps_in_t t;
        t = noise_item();
        t.cmd = CMD_FINISH;
        send_txn(t);
        t.cmd = CMD_FINISH_BOUNDS;
        t.pos_x = INT32_MIN;
        t.pos_y = INT32_MIN;
        t.pos_z = INT32_MIN;
        t.bound_max_x = INT32_MAX;
        t.bound_max_y = INT32_MAX;
        t.bound_max_z = INT32_MAX;
        send_txn(t);
    endtask

    // samples are scanned but finishes ignore them without a skeleton
    task automatic test_no_skeleton();
        slps_in_t t;
        apply_config(1'b0, 7'd64, 32'sh0000_8000, ONE_Q16, -32'sh0000_4000,
                     32'sh0003_0000);
        t = rand_sample();
        send_txn(t);
        t = rand_finish();
        t.cmd = CMD_FINISH;
        send_txn(t);
        t = rand_sample();
        send_txn(t);
        t = rand_finish();
        t.cmd = CMD_FINISH_BOUNDS;
        send_txn(t);
    endtask

    // a minimum stuck at the largest value is still found
    task automatic test_saturated_min();
        slps_in_t t;
        apply_config(1'b1, 7'd64, 32'sd0, 32'sd0, 32'sd0, INT32_MAX);
        t = rand_sample();
        send_txn(t);
        t = rand_finish();
        t.cmd = CMD_FINISH;
        send_txn(t);
    endtask

    // mostly complete scans, plus stray loads, noise and bare finishes
    task automatic run_random_scans(input int n_items);
        int sent;
        int kind;
        int k;
        slps_in_t t;
        sent = 0;
        while (sent < n_items) begin
            kind = int'($urandom_range(0, 9));
            if (kind < 7) begin
                k = int'($urandom_range(1, 5));
                repeat (k) send_txn(rand_sample());
                send_txn(rand_finish());
                sent += k + 1;
            end else if (kind == 7) begin
                t = noise_item();
                t.cmd = CMD_LOAD;
                t.matrix_value = rand_fix();
                send_txn(t);
                sent++;
            end else if (kind == 8) begin
                send_txn(noise_item());
                sent++;
            end else begin
                send_txn(rand_finish());
                sent++;
            end
        end
    endtask

    // register settings from typical to extreme, idling off at the end
    task automatic test_random_scans();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_config(1'b1, 7'd64, 32'sd0, ONE_Q16, 32'sd0, 32'sd0);
                1: apply_config(1'b1, 7'd1, rand_fix(), rand_fix(), rand_fix(), rand_fix());
                2: apply_config(1'b1, 7'd0, rand_fix(), rand_fix(), rand_fix(), rand_fix());
                3: apply_config(1'b0, 7'd64, rand_fix(), rand_fix(), rand_fix(), rand_fix());
                4: apply_config(1'b1, 7'd127, INT32_MAX, INT32_MIN, INT32_MAX, INT32_MIN);
                5: apply_config(1'b1, 7'($urandom_range(2, 63)), $urandom(), $urandom(),
                                $urandom(), $urandom());
                default: apply_config(1'b1, 7'd64, rand_fix(), rand_fix(), rand_fix(),
                                      rand_fix());
            endcase
            idle_on = (phase < 6);
            run_random_scans(PHASE_ITEMS);
        end
    endtask

    // main sequence
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        has_bones  = 1'b0;
        bone_limit = 0;
        ty_coef[0] = '0;
        ty_coef[1] = TY_Y_RESET;
        ty_coef[2] = '0;
        ty_coef[3] = '0;
        scan_min   = MIN_RESET;
        scan_hit   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        apply_config(1'b1, 7'd64, 32'sd0, ONE_Q16, 32'sd0, 32'sd0);
        test_fill_store();
        test_ignored_loads();
        test_field_extremes();
        test_skipped_joints();
        test_empty_scan();
        test_no_skeleton();
        test_saturated_min();
        test_random_scans();

        wait_drain();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
